/* src/atacc_pkg.sv */
// ----------------------------------------------------------------------------
// Affine transform accumulator package
// Shared types, command codes, sequencer states and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package atacc_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_FRAC     = 24;
    localparam int ONE_Q30      = 30;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [31:0] ONE_FX   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] D90      = 34'sd90 <<< ANG_FRAC;

    // Command codes.
    typedef enum logic [2:0] {
        OP_IDENT = 3'd0,
        OP_TRANS = 3'd1,
        OP_ROT   = 3'd2,
        OP_SCALE = 3'd3,
        OP_WRITE = 3'd4,
        OP_READ  = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] arg_a;
        logic signed [31:0] arg_b;
        logic [1:0]         row;
        logic [1:0]         col;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               index_ok;
        logic               saturated;
    } t_out_word;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FOLD,
        S_CORDIC,
        S_TRIG,
        S_MAC,
        S_SUM,
        S_COPY,
        S_DONE
    } t_state;

    // Arctangent of 2^-i in degrees, 24 fraction bits.
    function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
        unique case (i)
            5'd0:    atan_deg = 34'sd754974720;
            5'd1:    atan_deg = 34'sd445687602;
            5'd2:    atan_deg = 34'sd235489088;
            5'd3:    atan_deg = 34'sd119537938;
            5'd4:    atan_deg = 34'sd60000934;
            5'd5:    atan_deg = 34'sd30029717;
            5'd6:    atan_deg = 34'sd15018523;
            5'd7:    atan_deg = 34'sd7509720;
            5'd8:    atan_deg = 34'sd3754917;
            5'd9:    atan_deg = 34'sd1877466;
            5'd10:   atan_deg = 34'sd938734;
            5'd11:   atan_deg = 34'sd469367;
            5'd12:   atan_deg = 34'sd234684;
            5'd13:   atan_deg = 34'sd117342;
            5'd14:   atan_deg = 34'sd58671;
            5'd15:   atan_deg = 34'sd29335;
            5'd16:   atan_deg = 34'sd14668;
            5'd17:   atan_deg = 34'sd7334;
            5'd18:   atan_deg = 34'sd3667;
            5'd19:   atan_deg = 34'sd1833;
            5'd20:   atan_deg = 34'sd917;
            5'd21:   atan_deg = 34'sd458;
            5'd22:   atan_deg = 34'sd229;
            5'd23:   atan_deg = 34'sd115;
            default: atan_deg = 34'sd0;
        endcase
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                  output logic sat);
        sat = 1'b0;
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            clip32 = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            sat = 1'b1;
            clip32 = 32'sh80000000;
        end else begin
            clip32 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

/* src/atacc_cordic.sv */
// ----------------------------------------------------------------------------
// Cosine and sine unit
// Reduces a degree angle modulo 360 by compare and subtract, folds it and runs
// an iterative CORDIC, one rotation per cycle, giving cosine and sine in
// FRAC_BITS fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module atacc_cordic import atacc_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [31:0]  i_deg,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    localparam logic signed [40:0] FULL      = 41'sd360 <<< FRAC_BITS;
    // A negative angle is lifted by 128 turns, which makes it non-negative.
    localparam logic signed [40:0] FULL_WRAP = FULL <<< 7;
    // Largest multiple of a turn subtracted in the reduction.
    localparam logic signed [40:0] FULL_TOP  = FULL <<< 6;

    typedef enum logic [2:0] {C_IDLE, C_RED, C_FOLD, C_ITER, C_OUT} t_cst;

    t_cst               r_st, n_st;
    logic signed [40:0] r_r, n_r;
    logic signed [40:0] r_dv, n_dv;
    logic signed [33:0] r_x, n_x, r_y, n_y;
    logic signed [34:0] r_z, n_z;
    logic               r_neg, n_neg;
    logic [STEP_W-1:0]  r_i, n_i;
    logic signed [33:0] w_xf, w_yf;
    logic signed [33:0] w_dx, w_dy;
    logic signed [34:0] w_at;

    // State and data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_r   <= n_r;
        r_dv  <= n_dv;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_neg <= n_neg;
        r_i   <= n_i;
    end

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_at = 35'(atan_deg(5'(r_i)));
    assign w_xf = r_neg ? -r_x : r_x;
    assign w_yf = r_neg ? -r_y : r_y;

    // Sequencer: seven reduction steps, one fold, then the rotations.
    always_comb begin
        n_st   = r_st;
        n_r    = r_r;
        n_dv   = r_dv;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_neg  = r_neg;
        n_i    = r_i;
        o_done = 1'b0;
        unique case (r_st)
            C_IDLE: begin
                if (i_start) begin
                    n_r  = (i_deg < 0) ? 41'(i_deg) + FULL_WRAP : 41'(i_deg);
                    n_dv = FULL_TOP;
                    n_st = C_RED;
                end
            end
            C_RED: begin
                // Subtract 64, 32, ... 1 turns where they fit.
                if (r_r >= r_dv) begin
                    n_r = r_r - r_dv;
                end
                n_dv = r_dv >>> 1;
                if (r_dv == FULL) begin
                    n_st = C_FOLD;
                end
            end
            C_FOLD: begin
                n_z   = 35'(r_r) <<< (ANG_FRAC - FRAC_BITS);
                n_neg = 1'b0;
                if (n_z > 35'(D90)) begin
                    if (n_z <= 35'(D90) * 3) begin
                        n_z   = n_z - 35'(D90) * 2;
                        n_neg = 1'b1;
                    end else begin
                        n_z = n_z - 35'(D90) * 4;
                    end
                end
                n_x  = GAIN_Q30;
                n_y  = '0;
                n_i  = '0;
                n_st = C_ITER;
            end
            C_ITER: begin
                if (r_z >= 0) begin
                    n_x = r_x - w_dx;
                    n_y = r_y + w_dy;
                    n_z = r_z - w_at;
                end else begin
                    n_x = r_x + w_dx;
                    n_y = r_y - w_dy;
                    n_z = r_z + w_at;
                end
                n_i = r_i + 1'b1;
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_st = C_OUT;
                end
            end
            C_OUT: begin
                o_done = 1'b1;
                n_st   = C_IDLE;
            end
            default: n_st = C_IDLE;
        endcase
    end

    // Round from Q30 to FRAC_BITS.
    assign o_cos = 32'((w_xf + (34'sd1 <<< (ONE_Q30 - FRAC_BITS - 1)))
                       >>> (ONE_Q30 - FRAC_BITS));
    assign o_sin = 32'((w_yf + (34'sd1 <<< (ONE_Q30 - FRAC_BITS - 1)))
                       >>> (ONE_Q30 - FRAC_BITS));

    a_done_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_st) == C_ITER)
        else $error("trig done without iterations");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_st == C_IDLE)
        else $error("trig unit not idle after done");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == C_ITER |-> r_i < STEP_W'(CORDIC_STEPS))
        else $error("rotation count overran");

endmodule

`default_nettype wire

/* src/affine_transform_accumulator_2d.sv */
// ----------------------------------------------------------------------------
// 2D affine transform accumulator
// Holds a 3x3 Q16.16 matrix and applies one command per word.
// ----------------------------------------------------------------------------
// Each input word is taken only when the block is idle. Identity, write and
// read offer their result without the multiplier. Translate and scale run
// each of the 9 elements through three products on the single shared 32x32
// multiplier, one per cycle, then fold the last product and store the
// saturated sum; a copy back of all 9 elements follows. Rotate first runs
// the iterative sine and cosine unit: seven compare-and-subtract steps reduce
// the angle modulo 360, then a fold, one rotation per cycle and an output
// step; cosine and sine are then latched. The result register holds one
// word; the next input word is taken once the result has been handed over.
`default_nettype none

module affine_transform_accumulator_2d import atacc_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  wire       i_ready,
    output t_out_word o_data
);

    t_state             r_st, n_st;
    t_in_word           r_cmd;
    logic signed [31:0] r_m [9];
    logic signed [31:0] r_res [9];
    logic signed [31:0] r_c, r_s;
    logic [3:0]         r_e, n_e;
    logic [1:0]         r_k, n_k;
    logic signed [33:0] r_acc, n_acc;
    logic signed [63:0] r_prod;
    logic               r_sat, n_sat;
    logic               r_pv, n_pv;
    logic               r_ov;
    t_out_word          r_out;
    logic               w_ok, w_idx_ok;
    logic [3:0]         w_idx;
    logic               w_cstart, w_cdone;
    logic signed [31:0] w_cos, w_sin;
    logic signed [31:0] w_ma, w_tb;
    logic [1:0]         w_i, w_j;
    logic signed [31:0] w_pc, w_sum;
    logic               w_ps, w_ss;
    logic               w_last;
    logic               w_fin;

    atacc_cordic u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_deg   (r_cmd.arg_a),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_idx_ok = (r_cmd.row != 2'd3) && (r_cmd.col != 2'd3);
    assign w_idx    = 4'(r_cmd.row) * 4'd3 + 4'(r_cmd.col);
    assign w_i      = (r_e >= 4'd6) ? 2'd2 : (r_e >= 4'd3) ? 2'd1 : 2'd0;
    assign w_j      = 2'(r_e - 4'(w_i) * 4'd3);

    // Operand selection for the shared multiplier: m[i][k] by t[k][j].
    always_comb begin
        w_ma = r_m[4'(w_i) * 4'd3 + 4'(r_k)];
        w_tb = (r_k == w_j) ? ONE_FX : '0;
        unique case (t_op'(r_cmd.op))
            OP_TRANS: begin
                if (w_j == 2'd2 && r_k == 2'd0) w_tb = r_cmd.arg_a;
                if (w_j == 2'd2 && r_k == 2'd1) w_tb = r_cmd.arg_b;
            end
            OP_SCALE: begin
                if (w_j == 2'd0 && r_k == 2'd0) w_tb = r_cmd.arg_a;
                if (w_j == 2'd1 && r_k == 2'd1) w_tb = r_cmd.arg_b;
            end
            OP_ROT: begin
                if (w_j == 2'd0 && r_k == 2'd0) w_tb = r_c;
                if (w_j == 2'd1 && r_k == 2'd0) w_tb = -r_s;
                if (w_j == 2'd0 && r_k == 2'd1) w_tb = r_s;
                if (w_j == 2'd1 && r_k == 2'd1) w_tb = r_c;
            end
            default: ;
        endcase
        w_pc  = clip32((r_prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS, w_ps);
        // Final sum of an element: the two folded products plus the last one.
        w_sum = clip32(64'(r_acc) + 64'(w_pc), w_ss);
    end

    assign w_ok   = i_valid && o_ready;
    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign w_last = (r_e == 4'd8);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_pv <= n_pv;
            if (w_fin) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        r_e    <= n_e;
        r_k    <= n_k;
        r_acc  <= n_acc;
        r_sat  <= n_sat;
        r_prod <= 64'(w_ma) * 64'(w_tb);
        if (w_ok) begin
            r_cmd <= i_data;
        end
        if (w_cdone) begin
            r_c <= w_cos;
            r_s <= w_sin;
        end
    end

    // Matrix store, product buffer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 9; n++) begin
                r_m[n] <= (n % 4 == 0) ? ONE_FX : '0;
            end
        end else begin
            if (r_st == S_MOD && t_op'(r_cmd.op) == OP_IDENT) begin
                for (int n = 0; n < 9; n++) begin
                    r_m[n] <= (n % 4 == 0) ? ONE_FX : '0;
                end
            end
            if (r_st == S_MOD && t_op'(r_cmd.op) == OP_WRITE && w_idx_ok) begin
                r_m[w_idx] <= r_cmd.arg_a;
            end
            if (r_st == S_COPY) begin
                r_m[r_e] <= r_res[r_e];
            end
        end
        if (r_st == S_SUM) begin
            r_res[r_e] <= w_sum;
        end
        if (w_fin) begin
            r_out.read_value <= (t_op'(r_cmd.op) == OP_READ && w_idx_ok) ?
                                r_m[w_idx] : '0;
            r_out.index_ok   <= (t_op'(r_cmd.op) == OP_READ ||
                                 t_op'(r_cmd.op) == OP_WRITE) && w_idx_ok;
            r_out.saturated  <= r_sat;
        end
    end

    // Sequencer: products stream one per cycle while in S_MAC, the pipelined
    // product is rounded and accumulated in the next cycle. All nine sums are
    // kept aside and copied into the matrix only once the whole product is done.
    always_comb begin
        n_st     = r_st;
        n_e      = r_e;
        n_k      = r_k;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_pv     = 1'b0;
        w_cstart = 1'b0;
        w_fin    = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (w_ok) n_st = S_MOD;
            end
            S_MOD: begin
                n_sat = 1'b0;
                n_e   = '0;
                n_k   = '0;
                n_acc = '0;
                if (t_op'(r_cmd.op) == OP_ROT) begin
                    w_cstart = 1'b1;
                    n_st     = S_CORDIC;
                end else if (t_op'(r_cmd.op) == OP_TRANS ||
                             t_op'(r_cmd.op) == OP_SCALE) begin
                    n_st = S_MAC;
                end else begin
                    n_st = S_DONE;
                end
            end
            S_CORDIC: begin
                if (w_cdone) n_st = S_TRIG;
            end
            S_TRIG: begin
                n_st = S_MAC;
            end
            S_MAC: begin
                // Product for (e,k) issued now; fold the previous one.
                n_pv = 1'b1;
                if (r_pv) begin
                    n_acc = r_acc + 34'(w_pc);
                    n_sat = r_sat | w_ps;
                end
                if (r_k == 2'd2) begin
                    n_st = S_SUM;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_SUM: begin
                // The last product is folded and the element stored aside.
                n_sat = r_sat | w_ps | w_ss;
                n_acc = '0;
                n_k   = '0;
                if (w_last) begin
                    n_e  = '0;
                    n_st = S_COPY;
                end else begin
                    n_e  = r_e + 4'd1;
                    n_st = S_MAC;
                end
            end
            S_COPY: begin
                if (w_last) begin
                    n_e  = '0;
                    n_st = S_DONE;
                end else begin
                    n_e = r_e + 4'd1;
                end
            end
            S_DONE: begin
                w_fin = 1'b1;
                n_st  = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ok |-> r_st == S_IDLE && !r_ov)
        else $error("word taken while busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> o_valid)
        else $error("result lost");

    a_index_ok_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.index_ok |-> r_cmd.op == OP_READ || r_cmd.op == OP_WRITE)
        else $error("index flag on wrong command");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.index_ok |-> o_data.read_value == '0)
        else $error("read value without valid index");

endmodule

`default_nettype wire
